### rtl/qte_pkg.sv
// Shared types, constants and helper functions for the quaternion to Euler angle block.
package qte_pkg;

  // Input quaternion part, signed Q1.14.
  typedef logic signed [15:0] quat_t;
  // Product of two quaternion parts, signed Q.28.
  typedef logic signed [31:0] prod_t;
  // Rotation-matrix term, signed Q.28 with room for unnormalized inputs.
  typedef logic signed [34:0] rval_t;
  // Radicand of the pitch root and the root itself.
  typedef logic [56:0] rad_t;
  typedef logic [28:0] root_t;
  // CORDIC vector component and angle accumulator (radians, Q.24).
  typedef logic signed [33:0] cvec_t;
  typedef logic signed [27:0] ang_t;
  // Magnitude used by the atan2 range normalization.
  typedef logic [34:0] mag_t;

  // Matrix terms that travel together down the pipeline.
  typedef struct packed {
    rval_t r00;
    rval_t r10;
    rval_t r20;
    rval_t r21;
    rval_t r22;
  } rset_t;

  // One finished result in the output buffer.
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } res_t;

  localparam int SQRT_BITS    = 29;
  localparam int CORDIC_STEPS = 24;
  localparam int NORM_MSB     = 29;

  localparam rval_t ONE_Q28   = 35'sd268435456;
  localparam root_t MIN_DEN   = 29'd268435;
  localparam ang_t  HALF_PI   = 28'sd26353589;
  localparam logic signed [15:0] ANG_MAX   = 16'sd25736;
  localparam logic signed [15:0] PITCH_MAX = 16'sd12868;

  // atan(2^-i) in Q.24 for the first ten steps; later steps use 2^(24-i).
  localparam ang_t ATAN_TAB [0:9] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
    28'sd524117,   28'sd262123,  28'sd131069,  28'sd65536,   28'sd32768
  };

  // Rotation angle of CORDIC step i.
  function automatic ang_t step_angle(input int i);
    ang_t a;
    if (i < 10) begin
      a = ATAN_TAB[i];
    end else begin
      a = ang_t'(1) <<< (24 - i);
    end
    return a;
  endfunction

  // Round a Q.24 angle half up to Q2.13 (optionally negated first) and saturate.
  function automatic logic signed [15:0] round_sat(input ang_t a, input logic neg,
                                                   input logic signed [15:0] lim);
    logic signed [28:0] t;
    logic signed [17:0] r;
    logic signed [15:0] o;
    t = 29'(a);
    if (neg) begin
      t = -t;
    end
    t = t + 29'sd1024;
    r = 18'(t >>> 11);
    if (r > lim) begin
      o = lim;
    end else if (r < -lim) begin
      o = -lim;
    end else begin
      o = 16'(r);
    end
    return o;
  endfunction

endpackage

### rtl/quaternion_to_euler_angles.sv
// Top level, fully pipelined: quaternion (Q1.14) to radians, roll/yaw Q2.13, pitch Q1.13.
// The block takes one request per clock cycle while the output buffer has room. Each
// passes through multiply and add for the matrix terms, the bit-per-stage square root
// behind pitch and the three parallel atan2 units (normalization, pre-rotation and
// twenty-four CORDIC steps), then enters the output buffer. All stages advance together;
// in_ready drops only when the two-entry output buffer is full, so one finished result
// may wait without stopping the input, and a second waiting result halts the whole
// pipeline until the receiver takes one.
module quaternion_to_euler_angles (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_quat_x,
  input  logic signed [15:0]  in_quat_y,
  input  logic signed [15:0]  in_quat_z,
  input  logic signed [15:0]  in_quat_w,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_roll,
  output logic signed [14:0]  out_pitch,
  output logic signed [15:0]  out_yaw
);

  logic           en;
  logic           mat_valid, sq_valid;
  qte_pkg::rset_t mat_rs, sq_rs;
  qte_pkg::rad_t  mat_rad;
  qte_pkg::root_t den;
  logic           roll_valid, pitch_valid, yaw_valid;
  qte_pkg::ang_t  roll_ang, pitch_ang, yaw_ang;
  qte_pkg::res_t  res, res_out;
  logic           push;

  assign in_ready = en;

  qte_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .qx        (in_quat_x),
    .qy        (in_quat_y),
    .qz        (in_quat_z),
    .qw        (in_quat_w),
    .out_valid (mat_valid),
    .out_rs    (mat_rs),
    .out_rad   (mat_rad)
  );

  qte_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mat_valid),
    .in_rad    (mat_rad),
    .in_rs     (mat_rs),
    .out_valid (sq_valid),
    .out_rs    (sq_rs),
    .out_den   (den)
  );

  qte_atan2 u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_y      (sq_rs.r21),
    .in_x      (sq_rs.r22),
    .out_valid (roll_valid),
    .out_ang   (roll_ang)
  );

  qte_atan2 u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_y      (sq_rs.r20),
    .in_x      (qte_pkg::rval_t'(den)),
    .out_valid (pitch_valid),
    .out_ang   (pitch_ang)
  );

  qte_atan2 u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_y      (sq_rs.r10),
    .in_x      (sq_rs.r00),
    .out_valid (yaw_valid),
    .out_ang   (yaw_ang)
  );

  // Round to Q2.13 and saturate; pitch takes the negated angle.
  always_comb begin
    res.roll  = qte_pkg::round_sat(roll_ang, 1'b0, qte_pkg::ANG_MAX);
    res.pitch = 15'(qte_pkg::round_sat(pitch_ang, 1'b1, qte_pkg::PITCH_MAX));
    res.yaw   = qte_pkg::round_sat(yaw_ang, 1'b0, qte_pkg::ANG_MAX);
  end

  assign push = en & roll_valid;

  qte_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (res),
    .space     (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res_out)
  );

  assign out_roll  = res_out.roll;
  assign out_pitch = res_out.pitch;
  assign out_yaw   = res_out.yaw;

  // The three angle pipelines must stay in lock step.
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (roll_valid == pitch_valid) && (roll_valid == yaw_valid))
    else $error("angle pipelines out of step");

  // A delivered pitch stays inside its saturation range.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch <= 15'sd12868) && (out_pitch >= -15'sd12868))
    else $error("pitch outside range");

  // A result written into an empty buffer is offered in the next cycle.
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !out_valid) |=> out_valid)
    else $error("pushed result not offered");

endmodule

### rtl/qte_matrix.sv
// Rotation-matrix terms and the pitch root radicand, five register stages.
module qte_matrix (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  qte_pkg::quat_t  qx,
  input  qte_pkg::quat_t  qy,
  input  qte_pkg::quat_t  qz,
  input  qte_pkg::quat_t  qw,
  output logic            out_valid,
  output qte_pkg::rset_t  out_rs,
  output qte_pkg::rad_t   out_rad
);

  qte_pkg::prod_t xx_r, yy_r, zz_r, xy_r, zw_r, xz_r, yw_r, yz_r, xw_r;
  qte_pkg::rset_t rs2_r, rs3_r, rs4_r, rs5_r;
  qte_pkg::rset_t rs2_nxt;
  logic [27:0]    s3_r;
  logic           small3_r, small4_r;
  logic [33:0]    s_nxt;
  logic [55:0]    sq4_r;
  qte_pkg::rad_t  rad5_r;
  logic [28:0]    tq_nxt;
  logic           v1_r, v2_r, v3_r, v4_r, v5_r;

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Sums of products give the matrix terms.
  always_comb begin
    rs2_nxt.r00 = qte_pkg::ONE_Q28 -
                  ((qte_pkg::rval_t'(yy_r) + qte_pkg::rval_t'(zz_r)) <<< 1);
    rs2_nxt.r10 = (qte_pkg::rval_t'(xy_r) + qte_pkg::rval_t'(zw_r)) <<< 1;
    rs2_nxt.r20 = (qte_pkg::rval_t'(xz_r) - qte_pkg::rval_t'(yw_r)) <<< 1;
    rs2_nxt.r21 = (qte_pkg::rval_t'(yz_r) + qte_pkg::rval_t'(xw_r)) <<< 1;
    rs2_nxt.r22 = qte_pkg::ONE_Q28 -
                  ((qte_pkg::rval_t'(xx_r) + qte_pkg::rval_t'(yy_r)) <<< 1);
  end

  // Magnitude of R20 for the root argument.
  always_comb begin
    s_nxt = rs2_r.r20[34] ? 34'(-rs2_r.r20) : 34'(rs2_r.r20);
  end

  // One minus R20 squared, clamped at zero when |R20| reaches one.
  always_comb begin
    tq_nxt = 29'(qte_pkg::ONE_Q28) - {1'b0, sq4_r[55:28]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r     <= qx * qx;
      yy_r     <= qy * qy;
      zz_r     <= qz * qz;
      xy_r     <= qx * qy;
      zw_r     <= qz * qw;
      xz_r     <= qx * qz;
      yw_r     <= qy * qw;
      yz_r     <= qy * qz;
      xw_r     <= qx * qw;
      rs2_r    <= rs2_nxt;
      rs3_r    <= rs2_r;
      s3_r     <= s_nxt[27:0];
      small3_r <= (s_nxt[33:28] == 6'd0);
      rs4_r    <= rs3_r;
      sq4_r    <= s3_r * s3_r;
      small4_r <= small3_r;
      rs5_r    <= rs4_r;
      rad5_r   <= small4_r ? {tq_nxt, 28'd0} : '0;
    end
  end

  assign out_valid = v5_r;
  assign out_rs    = rs5_r;
  assign out_rad   = rad5_r;

endmodule

### rtl/qte_sqrt.sv
// Pipelined integer square root, one result bit per stage, floored at the minimum denominator.
module qte_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  qte_pkg::rad_t   in_rad,
  input  qte_pkg::rset_t  in_rs,
  output logic            out_valid,
  output qte_pkg::rset_t  out_rs,
  output qte_pkg::root_t  out_den
);

  localparam int N = qte_pkg::SQRT_BITS;

  qte_pkg::rad_t  rem_r [N];
  qte_pkg::root_t q_r   [N];
  qte_pkg::rset_t rs_r  [N];
  logic           v_r   [N];
  qte_pkg::root_t den_r;
  qte_pkg::rset_t rsf_r;
  logic           vf_r;

  for (genvar j = 0; j < N; j++) begin : g_bit
    localparam int B = N - 1 - j;
    qte_pkg::rad_t  rem_c;
    qte_pkg::root_t q_c;
    qte_pkg::rset_t rs_c;
    logic           v_c;
    logic [58:0]    trial;
    logic           take;

    if (j == 0) begin : g_first
      assign rem_c = in_rad;
      assign q_c   = '0;
      assign rs_c  = in_rs;
      assign v_c   = in_valid;
    end else begin : g_next
      assign rem_c = rem_r[j-1];
      assign q_c   = q_r[j-1];
      assign rs_c  = rs_r[j-1];
      assign v_c   = v_r[j-1];
    end

    // Try this bit: (q + 2^B)^2 - q^2 = (2q + 2^B) * 2^B.
    always_comb begin
      trial = (59'(q_c) << (B + 1)) + (59'(1) << (2 * B));
      take  = ({2'b00, rem_c} >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= take ? (rem_c - trial[56:0]) : rem_c;
        q_r[j]   <= take ? (q_c | (qte_pkg::root_t'(1) << B)) : q_c;
        rs_r[j]  <= rs_c;
      end
    end
  end

  // Keep the denominator away from zero near plus or minus ninety degrees.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= (q_r[N-1] < qte_pkg::MIN_DEN) ? qte_pkg::MIN_DEN : q_r[N-1];
      rsf_r <= rs_r[N-1];
    end
  end

  assign out_valid = vf_r;
  assign out_rs    = rsf_r;
  assign out_den   = den_r;

endmodule

### rtl/qte_atan2.sv
// Pipelined atan2: range normalization, quarter-turn pre-rotation and CORDIC vectoring.
module qte_atan2 (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  qte_pkg::rval_t  in_y,
  input  qte_pkg::rval_t  in_x,
  output logic            out_valid,
  output qte_pkg::ang_t   out_ang
);

  localparam int N = qte_pkg::CORDIC_STEPS;

  qte_pkg::rval_t x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  qte_pkg::mag_t  ax1_r, ay1_r, m2_r;
  logic [5:0]     p3_r, p_nxt;
  logic           zero3_r, zero4_r, zero5_r;
  qte_pkg::cvec_t x4_r, y4_r, x5_r, y5_r;
  qte_pkg::cvec_t x4_nxt, y4_nxt, x5_nxt, y5_nxt;
  qte_pkg::ang_t  z5_r, z5_nxt;
  logic           v1_r, v2_r, v3_r, v4_r, v5_r;

  qte_pkg::cvec_t cx_r [N];
  qte_pkg::cvec_t cy_r [N];
  qte_pkg::ang_t  cz_r [N];
  logic           cz0_r [N];
  logic           cv_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Position of the leading one of the larger magnitude.
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < 35; i++) begin
      if (m2_r[i]) begin
        p_nxt = 6'(i);
      end
    end
  end

  // Scale both operands so the larger magnitude lands in [2^29, 2^30).
  always_comb begin
    if (p3_r > 6'(qte_pkg::NORM_MSB)) begin
      x4_nxt = 34'(x3_r >>> (p3_r - 6'(qte_pkg::NORM_MSB)));
      y4_nxt = 34'(y3_r >>> (p3_r - 6'(qte_pkg::NORM_MSB)));
    end else begin
      x4_nxt = 34'(x3_r <<< (6'(qte_pkg::NORM_MSB) - p3_r));
      y4_nxt = 34'(y3_r <<< (6'(qte_pkg::NORM_MSB) - p3_r));
    end
  end

  // Vectors in the left half-plane are turned a quarter turn first.
  always_comb begin
    x5_nxt = x4_r;
    y5_nxt = y4_r;
    z5_nxt = '0;
    if (x4_r[33]) begin
      if (!y4_r[33]) begin
        x5_nxt = y4_r;
        y5_nxt = -x4_r;
        z5_nxt = qte_pkg::HALF_PI;
      end else begin
        x5_nxt = -y4_r;
        y5_nxt = x4_r;
        z5_nxt = -qte_pkg::HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= in_x;
      y1_r    <= in_y;
      ax1_r   <= in_x[34] ? 35'(-in_x) : 35'(in_x);
      ay1_r   <= in_y[34] ? 35'(-in_y) : 35'(in_y);
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      m2_r    <= (ax1_r > ay1_r) ? ax1_r : ay1_r;
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      p3_r    <= p_nxt;
      zero3_r <= (m2_r == '0);
      x4_r    <= x4_nxt;
      y4_r    <= y4_nxt;
      zero4_r <= zero3_r;
      x5_r    <= x5_nxt;
      y5_r    <= y5_nxt;
      z5_r    <= z5_nxt;
      zero5_r <= zero4_r;
    end
  end

  // CORDIC vectoring, one step per stage.
  for (genvar i = 0; i < N; i++) begin : g_step
    qte_pkg::cvec_t xc, yc, xs, ys, xn, yn;
    qte_pkg::ang_t  zc, zn;
    logic           zeroc, vc;

    if (i == 0) begin : g_first
      assign xc    = x5_r;
      assign yc    = y5_r;
      assign zc    = z5_r;
      assign zeroc = zero5_r;
      assign vc    = v5_r;
    end else begin : g_next
      assign xc    = cx_r[i-1];
      assign yc    = cy_r[i-1];
      assign zc    = cz_r[i-1];
      assign zeroc = cz0_r[i-1];
      assign vc    = cv_r[i-1];
    end

    always_comb begin
      xs = xc >>> i;
      ys = yc >>> i;
      if (!yc[33]) begin
        xn = xc + ys;
        yn = yc - xs;
        zn = zc + qte_pkg::step_angle(i);
      end else begin
        xn = xc - ys;
        yn = yc + xs;
        zn = zc - qte_pkg::step_angle(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i] <= 1'b0;
      end else if (en) begin
        cv_r[i] <= vc;
      end
    end

    // The zero vector gives an angle of zero.
    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i]  <= xn;
        cy_r[i]  <= yn;
        cz_r[i]  <= (i == N - 1 && zeroc) ? '0 : zn;
        cz0_r[i] <= zeroc;
      end
    end
  end

  assign out_valid = cv_r[N-1];
  assign out_ang   = cz_r[N-1];

endmodule

### rtl/qte_outbuf.sv
// Two-entry output buffer that lets the pipeline run while a result waits.
module qte_outbuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qte_pkg::res_t  din,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output qte_pkg::res_t  dout
);

  qte_pkg::res_t mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign space     = (cnt_r != 2'd2);
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule
